>>> design/tftp_client_transfer_engine_core_macros.svh
// assertion macros for the tftp client transfer engine core
// expects clk and rst in the scope of the module that uses them
`ifndef TFTP_CLIENT_TRANSFER_ENGINE_CORE_MACROS_SVH
`define TFTP_CLIENT_TRANSFER_ENGINE_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define TCE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define TCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/tftpce_pkg.sv
// types and codes shared by the tftp client transfer engine
// no dependencies
package tftpce_pkg;

  localparam int BLK_W     = 16;
  localparam int PLEN_W    = 10;
  localparam int FSIZE_W   = 25;
  localparam int RETRY_W   = 8;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_READ  = 2'd1,
    PH_WRITE = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    K_NONE = 2'd0,
    K_REQ  = 2'd1,
    K_ACK  = 2'd2,
    K_DATA = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_BUSY  = 3'd0,
    ST_DONE  = 3'd1,
    ST_PEER  = 3'd2,
    ST_RETRY = 3'd3,
    ST_IGN   = 3'd4
  } status_t;

  // event types
  localparam logic [1:0] EV_START   = 2'd0;
  localparam logic [1:0] EV_PACKET  = 2'd1;
  localparam logic [1:0] EV_TIMEOUT = 2'd2;

  // tftp opcodes
  localparam logic [15:0] OP_DATA  = 16'd3;
  localparam logic [15:0] OP_ACK   = 16'd4;
  localparam logic [15:0] OP_ERROR = 16'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRIES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FSIZE   = 2'd2;

  localparam logic [RETRY_W-1:0] RETRIES_RST = 8'd10;
  localparam logic [RETRY_W-1:0] RETRY_SAT   = 8'hFF;
  localparam logic [BLK_W-1:0]   BLK_LAST    = 16'hFFFF;

endpackage

>>> design/tftp_client_transfer_engine_core.sv
// tftp client transfer engine: event-driven control path of a tftp client
// uses tftpce_pkg and tftp_client_transfer_engine_core_macros.svh
//
// At most one event (start, received packet header or timeout) is taken per
// clock and gives exactly one result, which appears on the result port in the
// cycle after the event is taken and is held while res_stall is high. The event
// port stalls only while the result register holds a result that has not been
// taken, so with res_stall low the block sustains one event per cycle. All
// decisions are made in a single combinational pass over the transfer state;
// the next block length in write mode comes from a running byte offset, so
// no multiplier is needed. Configuration is written through cfg_we/cfg_index/
// cfg_data and should only change while no transfer result is pending.
`include "tftp_client_transfer_engine_core_macros.svh"

module tftp_client_transfer_engine_core #(
  parameter int BLOCK_BYTES = 512
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_we,
  input  logic [tftpce_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tftpce_pkg::FSIZE_W-1:0]       cfg_data,
  // event channel
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  logic [1:0]                           req_type,
  input  logic [15:0]                          pkt_opcode,
  input  logic [tftpce_pkg::BLK_W-1:0]         pkt_block,
  input  logic [tftpce_pkg::PLEN_W-1:0]        pkt_payload_len,
  // result channel
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output logic [1:0]                           send_kind,
  output logic [tftpce_pkg::BLK_W-1:0]         send_block,
  output logic [tftpce_pkg::PLEN_W-1:0]        send_len,
  output logic                                 store_payload,
  output logic [2:0]                           status,
  output logic [15:0]                          peer_error_code
);
  import tftpce_pkg::*;

  localparam int LEN_W = $clog2(BLOCK_BYTES + 1);
  localparam int CMP_W = (LEN_W > PLEN_W) ? LEN_W : PLEN_W;
  localparam int OFF_W = (BLK_W + $clog2(BLOCK_BYTES) > FSIZE_W) ?
                         BLK_W + $clog2(BLOCK_BYTES) : FSIZE_W;
  localparam logic [OFF_W-1:0] BB_OFF = OFF_W'(BLOCK_BYTES);
  localparam logic [LEN_W-1:0] BB_LEN = LEN_W'(BLOCK_BYTES);
  localparam logic [CMP_W-1:0] BB_CMP = CMP_W'(BLOCK_BYTES);

  // configuration registers
  logic                 transfer_mode;
  logic [RETRY_W-1:0]   max_retries;
  logic [FSIZE_W-1:0]   file_size_bytes;

  // transfer state
  phase_t               phase, phase_next;
  logic [BLK_W-1:0]     cur_block, cur_block_next;
  logic [RETRY_W-1:0]   retry_count, retry_count_next;
  logic [LEN_W-1:0]     cur_len, cur_len_next;
  logic                 req_acked, req_acked_next;
  logic [OFF_W-1:0]     end_off, end_off_next;  // byte offset past the current block

  // result being formed
  kind_t                r_kind;
  logic [BLK_W-1:0]     r_block;
  logic [PLEN_W-1:0]    r_len;
  logic                 r_store;
  status_t              r_status;
  logic [15:0]          r_code;

  logic                 accept;
  logic                 running;
  logic [RETRY_W-1:0]   retry_inc;
  logic                 retry_hit;
  logic [OFF_W-1:0]     prior_off;
  logic [OFF_W-1:0]     fsize_ext;
  logic [OFF_W-1:0]     remain;
  logic [LEN_W-1:0]     next_len;

  assign req_stall = res_valid & res_stall;
  assign accept    = req_valid & ~req_stall;
  assign running   = (phase == PH_READ) || (phase == PH_WRITE);

  // retry counter saturates; limit reached when it meets max_retries
  assign retry_inc = (retry_count != RETRY_SAT) ? retry_count + 8'd1 : retry_count;
  assign retry_hit = (retry_inc >= max_retries);

  // length of the block that starts at prior_off (first block before ack 0)
  assign prior_off = req_acked ? end_off : '0;
  assign fsize_ext = OFF_W'(file_size_bytes);
  assign remain    = fsize_ext - prior_off;
  always_comb begin
    if (prior_off > fsize_ext) begin
      next_len = '0;
    end else if (remain < BB_OFF) begin
      next_len = LEN_W'(remain);
    end else begin
      next_len = BB_LEN;
    end
  end

  always_comb begin
    phase_next       = phase;
    cur_block_next   = cur_block;
    retry_count_next = retry_count;
    cur_len_next     = cur_len;
    req_acked_next   = req_acked;
    end_off_next     = end_off;
    r_kind           = K_NONE;
    r_block          = '0;
    r_len            = '0;
    r_store          = 1'b0;
    r_status         = ST_IGN;
    r_code           = '0;
    case (req_type)
      EV_START: begin
        phase_next       = transfer_mode ? PH_WRITE : PH_READ;
        cur_block_next   = '0;
        retry_count_next = '0;
        cur_len_next     = '0;
        req_acked_next   = 1'b0;
        end_off_next     = '0;
        r_kind           = K_REQ;
        r_status         = ST_BUSY;
      end
      EV_TIMEOUT: begin
        if (running) begin
          retry_count_next = retry_inc;
          if (retry_hit) begin
            phase_next = PH_IDLE;
            r_status   = ST_RETRY;
          end else if (!req_acked) begin
            r_kind   = K_REQ;
            r_status = ST_BUSY;
          end else if (phase == PH_READ) begin
            r_kind   = K_ACK;
            r_block  = cur_block;
            r_status = ST_BUSY;
          end else begin
            r_kind   = K_DATA;
            r_block  = cur_block;
            r_len    = PLEN_W'(cur_len);
            r_status = ST_BUSY;
          end
        end
      end
      EV_PACKET: begin
        if (!running) begin
          r_status = ST_IGN;
        end else if (pkt_opcode == OP_ERROR) begin
          phase_next = PH_IDLE;
          r_status   = ST_PEER;
          r_code     = pkt_block;
        end else if (phase == PH_READ) begin
          if (pkt_opcode == OP_DATA) begin
            req_acked_next = 1'b1;
            r_kind         = K_ACK;
            if (pkt_block > cur_block) begin
              // newer block: take it; any length but a full block ends the transfer
              cur_block_next   = pkt_block;
              retry_count_next = '0;
              r_block          = pkt_block;
              r_store          = 1'b1;
              if (CMP_W'(pkt_payload_len) != BB_CMP) begin
                phase_next = PH_IDLE;
                r_status   = ST_DONE;
              end else begin
                r_status = ST_BUSY;
              end
            end else begin
              // duplicate: re-ack and count a retry
              retry_count_next = retry_inc;
              r_block          = cur_block;
              if (retry_hit) begin
                phase_next = PH_IDLE;
                r_status   = ST_RETRY;
              end else begin
                r_status = ST_BUSY;
              end
            end
          end
        end else begin
          if (pkt_opcode == OP_ACK) begin
            retry_count_next = '0;
            if (!req_acked) begin
              r_status = ST_BUSY;
              if (pkt_block == '0) begin
                req_acked_next = 1'b1;
                cur_block_next = 16'd1;
                cur_len_next   = next_len;
                end_off_next   = BB_OFF;
                r_kind         = K_DATA;
                r_block        = 16'd1;
                r_len          = PLEN_W'(next_len);
              end else begin
                r_kind = K_REQ;
              end
            end else if (pkt_block != cur_block) begin
              r_kind   = K_DATA;
              r_block  = cur_block;
              r_len    = PLEN_W'(cur_len);
              r_status = ST_BUSY;
            end else if (cur_len != BB_LEN) begin
              phase_next = PH_IDLE;
              r_status   = ST_DONE;
            end else if (cur_block == BLK_LAST) begin
              // block numbers do not wrap
              phase_next = PH_IDLE;
              r_status   = ST_RETRY;
            end else begin
              cur_block_next = cur_block + 16'd1;
              cur_len_next   = next_len;
              end_off_next   = end_off + BB_OFF;
              r_kind         = K_DATA;
              r_block        = cur_block + 16'd1;
              r_len          = PLEN_W'(next_len);
              r_status       = ST_BUSY;
            end
          end
        end
      end
      default: begin
        r_status = ST_IGN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      transfer_mode   <= 1'b0;
      max_retries     <= RETRIES_RST;
      file_size_bytes <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:    transfer_mode   <= cfg_data[0];
        CFG_RETRIES: max_retries     <= cfg_data[RETRY_W-1:0];
        CFG_FSIZE:   file_size_bytes <= cfg_data;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      cur_block   <= '0;
      retry_count <= '0;
      cur_len     <= '0;
      req_acked   <= 1'b0;
      end_off     <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      cur_block   <= cur_block_next;
      retry_count <= retry_count_next;
      cur_len     <= cur_len_next;
      req_acked   <= req_acked_next;
      end_off     <= end_off_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      send_kind       <= r_kind;
      send_block      <= r_block;
      send_len        <= r_len;
      store_payload   <= r_store;
      status          <= r_status;
      peer_error_code <= r_code;
    end
  end

  `TCE_ASSERT_NEXT(a_end_goes_idle, accept && (r_status == ST_DONE || r_status == ST_PEER || r_status == ST_RETRY), phase == PH_IDLE, "transfer end did not return to idle")
  `TCE_ASSERT_NOW(a_unacked_block_zero, !req_acked, cur_block == '0, "block advanced before request answered")
  `TCE_ASSERT_NOW(a_store_with_ack, res_valid && store_payload, send_kind == K_ACK, "payload stored without ack")
  `TCE_ASSERT_NOW(a_code_only_on_peer, res_valid && status != ST_PEER, peer_error_code == '0, "error code outside peer error")

endmodule

>>> sim/tftp_client_transfer_engine_core_test.sv
// self-checking testbench for tftp_client_transfer_engine_core
// depends on tftpce_pkg; predicts every result in-line and compares it in order
// directed transfers first, then a long write transfer, then random transfers
module tftp_client_transfer_engine_core_test;
  import tftpce_pkg::*;

  localparam int BLOCK_BYTES = 512;
  localparam int RUN_LIMIT_CYCLES = 1_000_000;
  localparam int PRINT_LIMIT = 40;
  localparam logic [1:0] EV_UNUSED = 2'd3;

  typedef struct packed {
    kind_t              kind;
    logic [BLK_W-1:0]   blk;
    logic [PLEN_W-1:0]  len;
    logic               store;
    status_t            st;
    logic [15:0]        code;
  } send_info_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FSIZE_W-1:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic [1:0] req_type = '0;
  logic [15:0] pkt_opcode = '0;
  logic [BLK_W-1:0] pkt_block = '0;
  logic [PLEN_W-1:0] pkt_payload_len = '0;
  logic res_stall = 1'b0;
  logic req_stall;
  logic res_valid;
  logic [1:0] send_kind;
  logic [BLK_W-1:0] send_block;
  logic [PLEN_W-1:0] send_len;
  logic store_payload;
  logic [2:0] status;
  logic [15:0] peer_error_code;

  // configuration copy and transfer state of the predictor
  logic mode_cfg = 1'b0;
  logic [RETRY_W-1:0] retries_cfg = RETRIES_RST;
  logic [FSIZE_W-1:0] fsize_cfg = '0;
  phase_t xfer_phase = PH_IDLE;
  logic [BLK_W-1:0] xfer_block = '0;
  logic [RETRY_W-1:0] retry_used = '0;
  logic [PLEN_W-1:0] xfer_len = '0;
  logic request_acked = 1'b0;

  send_info_t pending_sends[$];
  int unsigned items_sent = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  tftp_client_transfer_engine_core #(.BLOCK_BYTES(BLOCK_BYTES)) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_type(req_type),
    .pkt_opcode(pkt_opcode),
    .pkt_block(pkt_block),
    .pkt_payload_len(pkt_payload_len),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .send_kind(send_kind),
    .send_block(send_block),
    .send_len(send_len),
    .store_payload(store_payload),
    .status(status),
    .peer_error_code(peer_error_code)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // length of data block b in write mode, from the configured file size
  function automatic logic [PLEN_W-1:0] block_len(input logic [BLK_W-1:0] b);
    longint prior;
    longint upto;
    prior = (longint'(b) - 1) * BLOCK_BYTES;
    upto = longint'(b) * BLOCK_BYTES;
    if (b == 0 || prior > longint'(fsize_cfg))
      return '0;
    if (upto > longint'(fsize_cfg))
      return PLEN_W'(longint'(fsize_cfg) - prior);
    return PLEN_W'(BLOCK_BYTES);
  endfunction

  // counts one retry, saturating; true once the limit is reached
  function automatic bit count_retry();
    if (retry_used < RETRY_SAT)
      retry_used++;
    return retry_used >= retries_cfg;
  endfunction

  function automatic send_info_t predict_send(input logic [1:0] ev, input logic [15:0] op,
                                              input logic [BLK_W-1:0] blk,
                                              input logic [PLEN_W-1:0] plen);
    send_info_t r;
    r = '0;
    r.kind = K_NONE;
    r.st = ST_IGN;
    if (ev == EV_START) begin
      xfer_phase = mode_cfg ? PH_WRITE : PH_READ;
      xfer_block = '0;
      retry_used = '0;
      xfer_len = '0;
      request_acked = 1'b0;
      r.kind = K_REQ;
      r.st = ST_BUSY;
    end else if (ev == EV_UNUSED || xfer_phase == PH_IDLE) begin
      r.st = ST_IGN;
    end else if (ev == EV_TIMEOUT) begin
      if (count_retry()) begin
        xfer_phase = PH_IDLE;
        r.st = ST_RETRY;
      end else if (!request_acked) begin
        r.kind = K_REQ;
        r.st = ST_BUSY;
      end else if (xfer_phase == PH_READ) begin
        r.kind = K_ACK;
        r.blk = xfer_block;
        r.st = ST_BUSY;
      end else begin
        r.kind = K_DATA;
        r.blk = xfer_block;
        r.len = xfer_len;
        r.st = ST_BUSY;
      end
    end else if (op == OP_ERROR) begin
      xfer_phase = PH_IDLE;
      r.st = ST_PEER;
      r.code = blk;
    end else if (xfer_phase == PH_READ) begin
      if (op == OP_DATA) begin
        request_acked = 1'b1;
        r.kind = K_ACK;
        r.st = ST_BUSY;
        if (blk > xfer_block) begin
          xfer_block = blk;
          xfer_len = plen;
          retry_used = '0;
          r.store = 1'b1;
          // any length but a full block ends the read
          if (plen != PLEN_W'(BLOCK_BYTES)) begin
            xfer_phase = PH_IDLE;
            r.st = ST_DONE;
          end
        end else if (count_retry()) begin
          xfer_phase = PH_IDLE;
          r.st = ST_RETRY;
        end
        r.blk = xfer_block;
      end
    end else if (op == OP_ACK) begin
      retry_used = '0;
      r.st = ST_BUSY;
      if (!request_acked) begin
        if (blk == 0) begin
          request_acked = 1'b1;
          xfer_block = 16'd1;
          xfer_len = block_len(16'd1);
          r.kind = K_DATA;
          r.blk = xfer_block;
          r.len = xfer_len;
        end else begin
          r.kind = K_REQ;
        end
      end else if (blk != xfer_block) begin
        r.kind = K_DATA;
        r.blk = xfer_block;
        r.len = xfer_len;
      end else if (xfer_len != PLEN_W'(BLOCK_BYTES)) begin
        xfer_phase = PH_IDLE;
        r.st = ST_DONE;
      end else if (xfer_block >= BLK_LAST) begin
        // no block numbers left
        xfer_phase = PH_IDLE;
        r.st = ST_RETRY;
      end else begin
        xfer_block++;
        xfer_len = block_len(xfer_block);
        r.kind = K_DATA;
        r.blk = xfer_block;
        r.len = xfer_len;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    send_info_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_sends.size() == 0) begin
        report_mismatch("result with no request", {30'd0, send_kind}, 32'd0);
      end else begin
        want = pending_sends.pop_front();
        if (send_kind !== want.kind)
          report_mismatch("send_kind", 32'(send_kind), 32'(want.kind));
        if (send_block !== want.blk)
          report_mismatch("send_block", 32'(send_block), 32'(want.blk));
        if (send_len !== want.len)
          report_mismatch("send_len", 32'(send_len), 32'(want.len));
        if (store_payload !== want.store)
          report_mismatch("store_payload", 32'(store_payload), 32'(want.store));
        if (status !== want.st)
          report_mismatch("status", 32'(status), 32'(want.st));
        if (peer_error_code !== want.code)
          report_mismatch("peer_error_code", 32'(peer_error_code), 32'(want.code));
      end
    end
  end

  // sends one request and returns at the edge that takes it; valid stays high
  task automatic send_request(input logic [1:0] ev, input logic [15:0] op,
                              input logic [BLK_W-1:0] blk, input logic [PLEN_W-1:0] plen);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req_type <= ev;
    pkt_opcode <= op;
    pkt_block <= blk;
    pkt_payload_len <= plen;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_sends.push_back(predict_send(ev, op, blk, plen));
    items_sent++;
  endtask

  task automatic send_packet(input logic [15:0] op, input logic [BLK_W-1:0] blk,
                             input logic [PLEN_W-1:0] plen);
    send_request(EV_PACKET, op, blk, plen);
  endtask

  task automatic send_event(input logic [1:0] ev);
    send_request(ev, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 10'($urandom_range(0, 1023)));
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_sends.size() != 0) @(posedge clk);
  endtask

  task automatic load_config(input logic mode, input logic [RETRY_W-1:0] retries,
                             input logic [FSIZE_W-1:0] fsize);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data <= FSIZE_W'(mode);
    @(posedge clk);
    cfg_index <= CFG_RETRIES;
    cfg_data <= FSIZE_W'(retries);
    @(posedge clk);
    cfg_index <= CFG_FSIZE;
    cfg_data <= fsize;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    mode_cfg = mode;
    retries_cfg = retries;
    fsize_cfg = fsize;
  endtask

  task automatic test_idle_events();
    load_config(1'b0, RETRIES_RST, '0);
    send_event(EV_TIMEOUT);
    send_packet(OP_DATA, 16'd1, 10'd512);
    send_event(EV_UNUSED);
    send_packet(OP_ERROR, 16'd7, 10'd0);
  endtask

  task automatic test_read_transfer();
    load_config(1'b0, 8'd3, '0);
    send_event(EV_START);
    send_event(EV_TIMEOUT);
    send_event(EV_UNUSED);
    send_packet(OP_ACK, 16'd0, 10'd0);
    send_packet(16'hFFFF, 16'd1, 10'd1023);
    send_packet(OP_DATA, 16'd1, 10'd512);
    send_event(EV_TIMEOUT);
    send_packet(OP_DATA, 16'd1, 10'd512);
    send_packet(OP_DATA, 16'd2, 10'd512);
    send_packet(OP_DATA, 16'hFFFF, 10'd0);
    send_event(EV_TIMEOUT);
  endtask

  task automatic test_read_retry_limit();
    // a limit of zero fails on the first counted retry
    load_config(1'b0, 8'd0, '0);
    send_event(EV_START);
    send_event(EV_TIMEOUT);
    send_event(EV_START);
    send_packet(OP_DATA, 16'd0, 10'd512);
  endtask

  task automatic test_write_transfer();
    load_config(1'b1, 8'd255, 25'd1024);
    send_event(EV_START);
    send_packet(OP_ACK, 16'd9, 10'd0);
    send_packet(OP_DATA, 16'd0, 10'd512);
    send_packet(OP_ACK, 16'd0, 10'd0);
    send_packet(OP_ACK, 16'd0, 10'd0);
    send_event(EV_TIMEOUT);
    send_packet(OP_ACK, 16'd1, 10'd0);
    send_packet(OP_ACK, 16'd2, 10'd0);
    send_packet(OP_ACK, 16'd3, 10'd0);
  endtask

  task automatic test_peer_error_and_restart();
    load_config(1'b1, 8'd2, 25'd700);
    send_event(EV_START);
    send_event(EV_START);
    send_packet(OP_ACK, 16'd0, 10'd0);
    send_packet(OP_ERROR, 16'hFFFF, 10'd0);
    send_event(EV_TIMEOUT);
    send_event(EV_START);
    send_packet(OP_ERROR, 16'd0, 10'd0);
  endtask

  // forty full blocks and a short last one, then one ack past the end
  task automatic test_long_write();
    int b;
    load_config(1'b1, 8'd1, 25'd20580);
    send_event(EV_START);
    for (b = 0; b <= 42; b++)
      send_packet(OP_ACK, 16'(b), 10'($urandom_range(0, 1023)));
  endtask

  task automatic run_read_transfer();
    int unsigned nblk;
    int unsigned pick;
    int unsigned guard;
    logic [15:0] op;
    logic [BLK_W-1:0] nb;
    logic [PLEN_W-1:0] plen;
    send_event(EV_START);
    nblk = $urandom_range(1, 6);
    guard = 0;
    while (xfer_phase == PH_READ && guard < 60) begin
      guard++;
      pick = $urandom_range(99);
      nb = xfer_block + 1'b1;
      if (pick < 8) begin
        send_event(EV_TIMEOUT);
      end else if (pick < 14) begin
        send_packet(OP_DATA, 16'($urandom_range(0, xfer_block)), 10'($urandom_range(0, 1023)));
      end else if (pick < 18) begin
        op = 16'($urandom_range(0, 65535));
        if (op == OP_DATA || op == OP_ERROR)
          op = OP_ACK;
        send_packet(op, nb, 10'($urandom_range(0, 1023)));
      end else if (pick < 20) begin
        send_packet(OP_ERROR, 16'($urandom_range(0, 65535)), 10'($urandom_range(0, 1023)));
      end else if (pick < 23) begin
        send_packet(OP_DATA, xfer_block + 16'($urandom_range(2, 4)), 10'd512);
      end else begin
        plen = 10'd512;
        if (nb >= nblk)
          plen = ($urandom_range(9) == 0) ? 10'($urandom_range(513, 1023))
                                          : 10'($urandom_range(0, 511));
        send_packet(OP_DATA, nb, plen);
      end
    end
  endtask

  task automatic run_write_transfer();
    int unsigned pick;
    int unsigned guard;
    logic [15:0] op;
    send_event(EV_START);
    guard = 0;
    while (xfer_phase == PH_WRITE && guard < 80) begin
      guard++;
      pick = $urandom_range(99);
      if (pick < 7) begin
        send_event(EV_TIMEOUT);
      end else if (pick < 11) begin
        send_packet(OP_ACK, 16'($urandom_range(0, 65535)), 10'($urandom_range(0, 1023)));
      end else if (pick < 14) begin
        op = ($urandom_range(1) == 0) ? OP_DATA : 16'($urandom_range(6, 65535));
        send_packet(op, xfer_block, 10'($urandom_range(0, 1023)));
      end else if (pick < 16) begin
        send_packet(OP_ERROR, 16'($urandom_range(0, 65535)), 10'($urandom_range(0, 1023)));
      end else begin
        send_packet(OP_ACK, request_acked ? xfer_block : 16'd0, 10'($urandom_range(0, 1023)));
      end
    end
  endtask

  task automatic run_noise();
    int unsigned n;
    int unsigned sel;
    logic [15:0] op;
    n = $urandom_range(1, 5);
    repeat (n) begin
      sel = $urandom_range(3);
      op = (sel == 0) ? OP_DATA : (sel == 1) ? OP_ACK : (sel == 2) ? OP_ERROR
                                                                 : 16'($urandom_range(0, 65535));
      send_request(2'($urandom_range(0, 3)), op, 16'($urandom_range(0, 65535)),
                   10'($urandom_range(0, 1023)));
    end
  endtask

  task automatic test_random();
    int p;
    int c;
    int unsigned target;
    int unsigned pick;
    logic mode;
    logic [RETRY_W-1:0] retries;
    logic [FSIZE_W-1:0] fsize;
    for (p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 19 : (p == 1) ? 61 : 0;
      recv_stall_pct = (p == 0) ? 61 : (p == 1) ? 19 : 0;
      for (c = 0; c < 4; c++) begin
        mode = 1'((c + p) % 2);
        retries = (c == 0) ? 8'd1 : (c == 1) ? 8'd255 : (c == 2) ? 8'd0
                                                                  : 8'($urandom_range(2, 10));
        fsize = FSIZE_W'($urandom_range(0, 4) * BLOCK_BYTES +
                         ($urandom_range(1) ? $urandom_range(0, 511) : 0));
        if (c == 1)
          fsize = '0;
        load_config(mode, retries, fsize);
        target = items_sent + 85;
        while (items_sent < target) begin
          pick = $urandom_range(99);
          if (pick < 3)
            wait_drained();
          else if (pick < 20)
            run_noise();
          else if (mode_cfg)
            run_write_transfer();
          else
            run_read_transfer();
        end
      end
    end
  endtask

  initial begin
    send_idle_pct = 19;
    recv_stall_pct = 61;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_idle_events();
    test_read_transfer();
    test_read_retry_limit();
    test_write_transfer();
    test_peer_error_and_restart();
    test_long_write();
    test_random();
    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #(RUN_LIMIT_CYCLES * 12);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/tftpce_pkg.sv
design/tftp_client_transfer_engine_core.sv
sim/tftp_client_transfer_engine_core_test.sv
